// ----- rtl/core/qmi_pkg.sv -----
package qmi_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [ADDR_W:0]          sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // Command codes
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_INSERT = 2'd2
    } action_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } qmi_state_t;

    localparam addr_t ADDR_ONE  = addr_t'(1);
    localparam addr_t ADDR_BACK = addr_t'(QUEUE_DEPTH - 1);

    // Ring position base + off, wrapped at the queue depth
    function automatic addr_t ring_add(input addr_t base, input addr_t off);
        sum_t sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= sum_t'(QUEUE_DEPTH))
            sum = sum - sum_t'(QUEUE_DEPTH);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/qmi_cmd_if.sv -----
interface qmi_cmd_if
    import qmi_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/core/qmi_rsp_if.sv -----
interface qmi_rsp_if
    import qmi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]         item_count;

    modport source (output valid, output status, output removed_value, output item_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input item_count,
                    output ready);
endinterface

// ----- rtl/core/qmi_ram.sv -----
module qmi_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/queue_with_middle_insert_unit.sv -----
// Each command passes over the ring RAMs: read at accept, then write back at commit in S_EXEC,
// which waits while an unread result holds the output slot; no command is taken in between.
// The next command is taken while a finished result still waits in the output register.
// Reset (rst_n low, asynchronous) clears heads, counts, sequencer and output valid.
// Ring RAM contents are not cleared; the counts keep any unwritten entry from being read.
module queue_with_middle_insert_unit
    import qmi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qmi_cmd_if.sink   cmd,
    qmi_rsp_if.source rsp
);
    qmi_state_t state_reg, state_next;

    addr_t fh_head_reg, fh_head_next;
    addr_t bh_head_reg, bh_head_next;
    cnt_t  fh_cnt_reg,  fh_cnt_next;
    cnt_t  bh_cnt_reg,  bh_cnt_next;

    logic [ACT_W-1:0] act_reg;
    data_t            val_reg;

    logic             out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    data_t            removed_reg, removed_next;
    cnt_t             count_reg, count_next;

    logic  in_fire;
    logic  commit;
    logic  fh_we, bh_we;
    addr_t fh_waddr, bh_waddr;
    data_t fh_wdata, bh_wdata;
    logic [DATA_W-1:0] fh_rdata, bh_rdata;

    cnt_t  total;
    logic  full;
    logic  n_odd;
    addr_t fh_tail;
    addr_t bh_tail;

    // Ring RAMs for the two halves
    qmi_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(DATA_W)) u_fh_ram (
        .clk   (clk),
        .we    (fh_we),
        .waddr (fh_waddr),
        .wdata (fh_wdata),
        .re    (in_fire),
        .raddr (fh_head_reg),
        .rdata (fh_rdata)
    );

    qmi_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(DATA_W)) u_bh_ram (
        .clk   (clk),
        .we    (bh_we),
        .waddr (bh_waddr),
        .wdata (bh_wdata),
        .re    (in_fire),
        .raddr (bh_head_reg),
        .rdata (bh_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd.valid) state_next = S_EXEC;
            S_EXEC:  if (commit)    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            S_IDLE:  cmd.ready = 1'b1;
            S_EXEC:  commit    = !out_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    assign in_fire = cmd.valid && cmd.ready;

    // Queue bookkeeping
    assign total   = cnt_t'(fh_cnt_reg + bh_cnt_reg);
    assign full    = (total == cnt_t'(QUEUE_DEPTH));
    assign n_odd   = total[0];
    assign fh_tail = ring_add(fh_head_reg, fh_cnt_reg[ADDR_W-1:0]);
    assign bh_tail = ring_add(bh_head_reg, bh_cnt_reg[ADDR_W-1:0]);

    // Modify and write back; at most one item moves between halves
    always_comb
    begin
        fh_head_next = fh_head_reg;
        bh_head_next = bh_head_reg;
        fh_cnt_next  = fh_cnt_reg;
        bh_cnt_next  = bh_cnt_reg;
        fh_we        = 1'b0;
        bh_we        = 1'b0;
        fh_waddr     = fh_tail;
        bh_waddr     = bh_tail;
        fh_wdata     = val_reg;
        bh_wdata     = val_reg;
        status_next  = STAT_DONE;
        removed_next = '0;

        if (commit)
        begin
            case (act_reg)
                ACT_APPEND:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else if (n_odd)
                    begin
                        bh_we       = 1'b1;
                        bh_cnt_next = bh_cnt_reg + cnt_t'(1);
                    end
                    else if (bh_cnt_reg == '0)
                    begin
                        // empty queue: item lands straight in the front half
                        fh_we       = 1'b1;
                        fh_cnt_next = fh_cnt_reg + cnt_t'(1);
                    end
                    else
                    begin
                        // push at back, rotate back-half head into front half
                        bh_we        = 1'b1;
                        bh_head_next = ring_add(bh_head_reg, ADDR_ONE);
                        fh_we        = 1'b1;
                        fh_wdata     = data_t'(bh_rdata);
                        fh_cnt_next  = fh_cnt_reg + cnt_t'(1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (total == '0)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        removed_next = data_t'(fh_rdata);
                        fh_head_next = ring_add(fh_head_reg, ADDR_ONE);
                        if (n_odd)
                            fh_cnt_next = fh_cnt_reg - cnt_t'(1);
                        else
                        begin
                            // refill front half from back-half head
                            fh_we        = 1'b1;
                            fh_wdata     = data_t'(bh_rdata);
                            bh_head_next = ring_add(bh_head_reg, ADDR_ONE);
                            bh_cnt_next  = bh_cnt_reg - cnt_t'(1);
                        end
                    end
                end
                ACT_INSERT:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else if (n_odd)
                    begin
                        // middle slot is the back half's new front
                        bh_head_next = ring_add(bh_head_reg, ADDR_BACK);
                        bh_waddr     = ring_add(bh_head_reg, ADDR_BACK);
                        bh_we        = 1'b1;
                        bh_cnt_next  = bh_cnt_reg + cnt_t'(1);
                    end
                    else
                    begin
                        fh_we       = 1'b1;
                        fh_cnt_next = fh_cnt_reg + cnt_t'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign count_next = cnt_t'(fh_cnt_next + bh_cnt_next);

    // Output slot
    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fh_head_reg   <= '0;
            bh_head_reg   <= '0;
            fh_cnt_reg    <= '0;
            bh_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fh_head_reg   <= fh_head_next;
            bh_head_reg   <= bh_head_next;
            fh_cnt_reg    <= fh_cnt_next;
            bh_cnt_reg    <= bh_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= cmd.action;
            val_reg <= cmd.value;
        end
        if (commit)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            count_reg   <= count_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.item_count    = count_reg;

    // Front half holds ceil(n/2): equal counts or one more in front
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (fh_cnt_reg == bh_cnt_reg) || (fh_cnt_reg == bh_cnt_reg + cnt_t'(1)))
        else $error("queue halves out of balance");

    // Total never exceeds the depth
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= cnt_t'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // An accepted command goes to the write-back state
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

    // A write-back always leaves a result in the output slot
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("write-back without result");

endmodule
